/* rtl/dsc_pkg.sv */
package dsc_pkg;

    localparam int unsigned COUNT_W    = 64;
    localparam int unsigned SYM_W      = 8;
    localparam int unsigned POS_W      = 6;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned CFG_LEN_W  = 7;
    localparam int unsigned GROUP_SIZE = 8;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FEED    = 2'd2;

    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic             clear;
        logic             feed;
        logic [SYM_W-1:0] sym;
    } cell_ctl_t;

endpackage

/* rtl/dsc_cell.sv */
module dsc_cell
    import dsc_pkg::*;
(
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  logic      load,
    input  logic      active,
    input  count_t    below,
    output count_t    count,
    output logic      wrap
);

    logic [SYM_W-1:0] sym_reg;
    count_t           count_reg;
    count_t           count_next;
    logic             hit;
    logic [COUNT_W:0] sum;

    assign hit   = ctl.feed && active && (ctl.sym == sym_reg);
    assign sum   = {1'b0, count_reg} + {1'b0, below};
    assign wrap  = hit && sum[COUNT_W];
    assign count = count_reg;

    always_comb begin
        if (ctl.clear) begin
            count_next = '0;
        end else if (hit) begin
            count_next = sum[COUNT_W-1:0];
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sym_reg <= ctl.sym;
        end
        count_reg <= count_next;
    end

endmodule

/* rtl/dsc_group.sv */
module dsc_group
    import dsc_pkg::*;
(
    input  logic                           aclk,
    input  logic                           en,
    input  count_t [GROUP_SIZE-1:0]        counts,
    input  logic   [GROUP_SIZE-1:0]        last,
    output count_t                         merged
);

    count_t merged_reg;
    count_t merged_next;

    always_comb begin
        merged_next = '0;
        for (int k = 0; k < GROUP_SIZE; k++) begin
            merged_next = merged_next | (counts[k] & {COUNT_W{last[k]}});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            merged_reg <= merged_next;
        end
    end

    assign merged = merged_reg;

endmodule

/* rtl/distinct_subsequence_counter.sv */
// channel  | ports                     | contents
// ---------+---------------------------+------------------------------------------
// input    | s_tvalid s_tready         | s_tuser: cmd; s_tdata: symbol, position
// result   | m_tvalid m_tready         | m_tuser: wrapped; m_tdata: match_count
// config   | cfg_wen cfg_wdata         | pattern_length
//
// cells update at the accept edge of a word; then the two-level or tree picks the last active
// cell's count: group registers load in ST_GATHER, the result register in ST_REDUCE.
// the result register parts the sides: the next word is taken while a result waits.
// a stalled result holds the tree in its last level until m_tready frees the register.
// aresetn clears counts, wrap flag, length and handshake state; pattern symbols are not reset.
module distinct_subsequence_counter
    import dsc_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [CFG_LEN_W-1:0] cfg_wdata,  // pattern_length
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,    // symbol [7:0], position [13:8]
    input  logic [CMD_W-1:0]     s_tuser,    // cmd [1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [COUNT_W-1:0]   m_tdata,    // match_count [63:0]
    output logic                 m_tuser     // wrapped [0]
);

    localparam int unsigned LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int unsigned NGROUP = (MAX_PATTERN + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int unsigned NPAD   = NGROUP * GROUP_SIZE;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATHER,
        ST_REDUCE
    } state_t;

    state_t               state_reg;
    logic [CFG_LEN_W-1:0] pattern_length_reg;
    logic                 wrap_reg;
    logic                 m_tvalid_reg;
    count_t               m_tdata_reg;
    logic                 m_tuser_reg;

    logic [LEN_W-1:0]     act_len;
    logic                 s_acc;
    logic [SYM_W-1:0]     s_symbol;
    logic [POS_W-1:0]     s_position;
    cell_ctl_t            ctl;
    count_t [MAX_PATTERN-1:0] cnt;
    count_t [MAX_PATTERN-1:0] below;
    logic   [MAX_PATTERN-1:0] wrap_vec;
    count_t [NPAD-1:0]    cnt_all;
    logic   [NPAD-1:0]    last_all;
    count_t [NGROUP-1:0]  merged;
    count_t               reduce_val;

    assign s_symbol   = s_tdata[SYM_W-1:0];
    assign s_position = s_tdata[SYM_W+POS_W-1:SYM_W];
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_acc      = s_tvalid && s_tready;

    assign act_len = (32'(pattern_length_reg) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN)
                                                             : LEN_W'(pattern_length_reg);

    assign ctl.clear = !aresetn || (s_acc && (s_tuser == CMD_RESTART));
    assign ctl.feed  = s_acc && (s_tuser == CMD_FEED);
    assign ctl.sym   = s_symbol;

    genvar i;
    generate
        for (i = 0; i < NPAD; i++) begin : g_cell
            if (i < MAX_PATTERN) begin : g_real
                if (i == 0) begin : g_first
                    assign below[i] = COUNT_W'(1);
                end else begin : g_next
                    assign below[i] = cnt[i-1];
                end
                dsc_cell u_cell (
                    .aclk   (aclk),
                    .ctl    (ctl),
                    .load   (s_acc && (s_tuser == CMD_LOAD) && (32'(s_position) == i)),
                    .active (32'(act_len) > i),
                    .below  (below[i]),
                    .count  (cnt[i]),
                    .wrap   (wrap_vec[i])
                );
                assign cnt_all[i]  = cnt[i];
                assign last_all[i] = (32'(act_len) == i + 1);
            end else begin : g_pad
                assign cnt_all[i]  = '0;
                assign last_all[i] = 1'b0;
            end
        end

        for (i = 0; i < NGROUP; i++) begin : g_grp
            dsc_group u_group (
                .aclk   (aclk),
                .en     (state_reg == ST_GATHER),
                .counts (cnt_all[i*GROUP_SIZE +: GROUP_SIZE]),
                .last   (last_all[i*GROUP_SIZE +: GROUP_SIZE]),
                .merged (merged[i])
            );
        end
    endgenerate

    always_comb begin
        reduce_val = '0;
        for (int g = 0; g < NGROUP; g++) begin
            reduce_val = reduce_val | merged[g];
        end
        if (act_len == '0) begin
            reduce_val = COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= '0;
        end else if (cfg_wen) begin
            pattern_length_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_reg <= 1'b0;
        end else if (s_acc && (s_tuser == CMD_RESTART)) begin
            wrap_reg <= 1'b0;
        end else if (ctl.feed && (|wrap_vec)) begin
            wrap_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (s_acc) begin
                        state_reg <= ST_GATHER;
                    end
                end
                ST_GATHER: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                    end
                    state_reg <= ST_REDUCE;
                end
                ST_REDUCE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= reduce_val;
                        m_tuser_reg  <= wrap_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_accept_gathers: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_GATHER))
        else $error("accepted word did not start the gather");

    a_restart_clears_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_RESTART)) |=> !wrap_reg)
        else $error("wrap flag survived a restart");

    a_empty_pattern_one: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_REDUCE) && (act_len == '0) && (!m_tvalid || m_tready))
        |=> (m_tvalid && (m_tdata == COUNT_W'(1))))
        else $error("empty pattern must count one");
`endif

endmodule
